@@ rtl/prt_pkg.sv @@
// Package with the shared types and constants of the pending acknowledgement table.
`default_nettype none

package prt_pkg;

    localparam int unsigned SlotW      = 4;
    localparam int unsigned CntW       = 5;
    localparam int unsigned AttW       = 8;
    localparam int unsigned DataW      = 32;
    localparam int unsigned QueueDepth = 2;

    localparam logic [CntW-1:0] MaxReports = 5'd16;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_RESOLVE = 2'd1,
        OP_TICK    = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        KIND_ADD     = 3'd0,
        KIND_RESOLVE = 3'd1,
        KIND_RETRY   = 3'd2,
        KIND_FAILED  = 3'd3,
        KIND_TICK    = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        REG_INTERVAL  = 2'd0,
        REG_ATTEMPTS  = 2'd1,
        REG_RETRY_RPT = 2'd2,
        REG_FAIL_RPT  = 2'd3
    } t_reg;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_SCAN   = 2'd1,
        ST_FINISH = 2'd2
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [DataW-1:0] msg_id;
        logic [DataW-1:0] dest;
        logic [DataW-1:0] now;
    } t_cmd;

    typedef struct packed {
        logic [DataW-1:0] interval;
        logic [AttW-1:0]  attempt_limit;
        logic [CntW-1:0]  retry_rpt;
        logic [CntW-1:0]  fail_rpt;
    } t_cfg;

    typedef struct packed {
        logic [DataW-1:0] key;
        logic [DataW-1:0] dest;
        logic [DataW-1:0] last;
        logic [AttW-1:0]  att;
    } t_entry;

    typedef struct packed {
        t_kind            kind;
        logic [SlotW-1:0] slot;
        logic             found;
        logic [DataW-1:0] out_id;
        logic [CntW-1:0]  retry_count;
        logic [CntW-1:0]  failed_count;
        logic             final_res;
    } t_res;

endpackage

`default_nettype wire

@@ rtl/prt_ifs.sv @@
// Valid/ready channel interfaces for the input and result beats.
`default_nettype none

interface prt_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [31:0] msg_id;
    logic [31:0] dest;
    logic [31:0] now;

    modport source (output valid, operation, msg_id, dest, now, input ready);
    modport sink (input valid, operation, msg_id, dest, now, output ready);
endinterface

interface prt_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic        found;
    logic [31:0] out_id;
    logic [4:0]  retry_count;
    logic [4:0]  failed_count;
    logic        final_res;

    modport source (output valid, kind, slot, found, out_id, retry_count, failed_count,
                    final_res, input ready);
    modport sink (input valid, kind, slot, found, out_id, retry_count, failed_count,
                  final_res, output ready);
endinterface

`default_nettype wire

@@ rtl/pending_ack_retry_table_top.sv @@
// Top level of the pending acknowledgement table with its register port.
//
//   Channel   Direction  Handshake                Content
//   i_in      in         valid/ready              operation, msg_id, dest, now
//   o_out     out        valid/ready              kind, slot, found, out_id, counts, final_res
//   APB       in/out     psel/penable/pwrite      four registers at byte offsets 0, 4, 8, 12
//
// Every operation walks the entry memory one slot per cycle, when not stalled, through its
// single read port: an item is dispatched from idle, scanned and then finished. A stalled
// result beat holds the scan until it is taken; the front register and the two-entry
// command queue keep accepting up to three input beats meanwhile.
// Reset clears the valid bits at once.
`default_nettype none

module pending_ack_retry_table_top #(
    parameter int unsigned ENTRIES = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    prt_in_if.sink           i_in,
    prt_out_if.source        o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import prt_pkg::*;

    t_cfg r_cfg;
    t_cmd front_cmd;
    logic front_valid;
    logic queue_ready;
    t_cmd queue_cmd;
    logic queue_valid;
    logic back_ready;
    t_reg reg_sel;
    logic cfg_wr;

    assign pready  = 1'b1;
    assign reg_sel = t_reg'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interval      <= 32'd5;
            r_cfg.attempt_limit <= 8'd3;
            r_cfg.retry_rpt     <= 5'd16;
            r_cfg.fail_rpt      <= 5'd16;
        end else if (cfg_wr) begin
            case (reg_sel)
                REG_INTERVAL:  r_cfg.interval      <= pwdata;
                REG_ATTEMPTS:  r_cfg.attempt_limit <= pwdata[AttW-1:0];
                REG_RETRY_RPT: r_cfg.retry_rpt     <= pwdata[CntW-1:0];
                REG_FAIL_RPT:  r_cfg.fail_rpt      <= pwdata[CntW-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_INTERVAL:  prdata = r_cfg.interval;
            REG_ATTEMPTS:  prdata = 32'(r_cfg.attempt_limit);
            REG_RETRY_RPT: prdata = 32'(r_cfg.retry_rpt);
            REG_FAIL_RPT:  prdata = 32'(r_cfg.fail_rpt);
            default:       prdata = '0;
        endcase
    end

    prt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd       (front_cmd),
        .o_cmd_valid (front_valid),
        .i_cmd_ready (queue_ready)
    );

    prt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (front_cmd),
        .i_valid (front_valid),
        .o_ready (queue_ready),
        .o_cmd   (queue_cmd),
        .o_valid (queue_valid),
        .i_ready (back_ready)
    );

    prt_back #(
        .ENTRIES (ENTRIES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_cmd_valid (queue_valid),
        .o_cmd_ready (back_ready),
        .i_cfg       (r_cfg),
        .o_out       (o_out)
    );

endmodule

`default_nettype wire

@@ rtl/prt_front.sv @@
// Front end that accepts input beats, decodes the operation and drops unknown codes.
`default_nettype none

module prt_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    prt_in_if.sink              i_in,
    output prt_pkg::t_cmd       o_cmd,
    output logic                o_cmd_valid,
    input  wire logic           i_cmd_ready
);
    import prt_pkg::*;

    logic r_vld;
    t_cmd r_cmd;
    logic known;

    assign known = (i_in.operation == OP_ADD) || (i_in.operation == OP_RESOLVE) ||
                   (i_in.operation == OP_TICK);
    assign i_in.ready  = !r_vld || i_cmd_ready;
    assign o_cmd_valid = r_vld;
    assign o_cmd       = r_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_vld <= i_in.valid && known;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_cmd.op     <= t_op'(i_in.operation);
            r_cmd.msg_id <= i_in.msg_id;
            r_cmd.dest   <= i_in.dest;
            r_cmd.now    <= i_in.now;
        end
    end

endmodule

`default_nettype wire

@@ rtl/prt_queue.sv @@
// Short command queue between the front end and the table sequencer.
`default_nettype none

module prt_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire prt_pkg::t_cmd  i_cmd,
    input  wire logic           i_valid,
    output logic                o_ready,
    output prt_pkg::t_cmd       o_cmd,
    output logic                o_valid,
    input  wire logic           i_ready
);
    import prt_pkg::*;

    localparam int unsigned PtrW = $clog2(QueueDepth);
    localparam int unsigned FillW = $clog2(QueueDepth + 1);

    t_cmd             r_buf [QueueDepth];
    logic [PtrW-1:0]  r_wp;
    logic [PtrW-1:0]  r_rp;
    logic [FillW-1:0] r_cnt;
    logic             push;
    logic             pop;

    assign o_ready = (r_cnt != FillW'(QueueDepth));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_buf[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wp] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/prt_back.sv @@
// Table sequencer: walks the entry memory one slot per cycle unless stalled, emits result beats.
`default_nettype none

module prt_back #(
    parameter int unsigned ENTRIES = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire prt_pkg::t_cmd  i_cmd,
    input  wire logic           i_cmd_valid,
    output logic                o_cmd_ready,
    input  wire prt_pkg::t_cfg  i_cfg,
    prt_out_if.source           o_out
);
    import prt_pkg::*;

    localparam int unsigned IdxW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int unsigned PosW = $clog2(ENTRIES + 1);

    t_entry             r_mem [ENTRIES];
    t_entry             r_rdata;
    logic [ENTRIES-1:0] r_valid;
    t_state             r_state;
    t_state             n_state;
    t_cmd               r_cmd;
    logic [PosW-1:0]    r_rd_idx;
    logic [IdxW-1:0]    r_ev_idx;
    logic               r_ev_vld;
    logic               r_hit;
    logic [IdxW-1:0]    r_hit_idx;
    logic               r_free;
    logic [IdxW-1:0]    r_free_idx;
    logic [IdxW-1:0]    r_min_idx;
    logic [DataW-1:0]   r_min_last;
    logic [CntW-1:0]    r_nr;
    logic [CntW-1:0]    r_nf;
    logic [CntW-1:0]    r_nk;
    logic               r_out_vld;
    t_res               r_out;

    logic             out_free;
    logic             ev_valid;
    logic             due;
    logic             retry;
    logic             act;
    logic             rep_ok;
    logic             emit_scan;
    logic             stall;
    logic             adv;
    logic             rd_en;
    logic             start;
    logic             fin_go;
    logic             scan_end;
    logic [IdxW-1:0]  add_slot;
    logic             wr_en;
    logic [IdxW-1:0]  wr_addr;
    t_entry           wr_data;
    t_res             scan_res;
    t_res             fin_res;

    assign out_free  = !r_out_vld || o_out.ready;
    assign ev_valid  = r_valid[r_ev_idx];
    assign due       = (r_cmd.now - r_rdata.last) >= i_cfg.interval;
    assign retry     = r_rdata.att < i_cfg.attempt_limit;
    assign act       = (r_state == ST_SCAN) && r_ev_vld && (r_cmd.op == OP_TICK) &&
                       ev_valid && due;
    assign rep_ok    = (r_nk < MaxReports) &&
                       (retry ? (r_nr < i_cfg.retry_rpt) : (r_nf < i_cfg.fail_rpt));
    assign emit_scan = act && rep_ok;
    assign stall     = emit_scan && !out_free;
    assign adv       = (r_state == ST_SCAN) && !stall;
    assign rd_en     = adv && (r_rd_idx != PosW'(ENTRIES));
    assign scan_end  = (r_rd_idx == PosW'(ENTRIES)) && !r_ev_vld;
    assign fin_go    = (r_state == ST_FINISH) && out_free;
    assign start     = (r_state == ST_IDLE) && i_cmd_valid;
    assign add_slot  = r_hit ? r_hit_idx : (r_free ? r_free_idx : r_min_idx);

    always_comb begin
        n_state     = r_state;
        o_cmd_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_cmd_ready = 1'b1;
                if (i_cmd_valid) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (scan_end) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_ev_idx;
        wr_data = r_rdata;
        if (act && retry && !stall) begin
            wr_en        = 1'b1;
            wr_data.att  = r_rdata.att + 1'b1;
            wr_data.last = r_cmd.now;
        end else if (fin_go && (r_cmd.op == OP_ADD)) begin
            wr_en        = 1'b1;
            wr_addr      = add_slot;
            wr_data.key  = r_cmd.msg_id;
            wr_data.dest = r_cmd.dest;
            wr_data.last = r_cmd.now;
            wr_data.att  = AttW'(1);
        end
    end

    always_comb begin
        scan_res              = '0;
        scan_res.kind         = retry ? KIND_RETRY : KIND_FAILED;
        scan_res.slot         = SlotW'(r_ev_idx);
        scan_res.out_id       = r_rdata.key;
        fin_res               = '0;
        fin_res.final_res     = 1'b1;
        case (r_cmd.op)
            OP_ADD: begin
                fin_res.kind = KIND_ADD;
                fin_res.slot = SlotW'(add_slot);
            end
            OP_RESOLVE: begin
                fin_res.kind  = KIND_RESOLVE;
                fin_res.found = r_hit;
                fin_res.slot  = r_hit ? SlotW'(r_hit_idx) : '0;
            end
            default: begin
                fin_res.kind         = KIND_TICK;
                fin_res.retry_count  = r_nr;
                fin_res.failed_count = r_nf;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_out_vld <= 1'b0;
            r_ev_vld  <= 1'b0;
            r_valid   <= '0;
        end else begin
            r_state <= n_state;
            if ((emit_scan && !stall) || fin_go) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            if (start) begin
                r_ev_vld <= 1'b0;
            end else if (adv) begin
                r_ev_vld <= rd_en;
            end
            if (act && !retry && !stall) begin
                r_valid[r_ev_idx] <= 1'b0;
            end
            if (fin_go && (r_cmd.op == OP_ADD)) begin
                r_valid[add_slot] <= 1'b1;
            end
            if (fin_go && (r_cmd.op == OP_RESOLVE) && r_hit) begin
                r_valid[r_hit_idx] <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_cmd    <= i_cmd;
            r_rd_idx <= '0;
            r_hit    <= 1'b0;
            r_free   <= 1'b0;
            r_nr     <= '0;
            r_nf     <= '0;
            r_nk     <= '0;
        end else if (adv) begin
            if (rd_en) begin
                r_rd_idx <= r_rd_idx + 1'b1;
                r_ev_idx <= r_rd_idx[IdxW-1:0];
            end
            if (r_ev_vld) begin
                if (!r_hit && ev_valid && (r_rdata.key == r_cmd.msg_id)) begin
                    r_hit     <= 1'b1;
                    r_hit_idx <= r_ev_idx;
                end
                if (!r_free && !ev_valid) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_ev_idx;
                end
                if ((r_ev_idx == '0) || (r_rdata.last < r_min_last)) begin
                    r_min_idx  <= r_ev_idx;
                    r_min_last <= r_rdata.last;
                end
            end
            if (emit_scan) begin
                r_nk <= r_nk + 1'b1;
                if (retry) begin
                    r_nr <= r_nr + 1'b1;
                end else begin
                    r_nf <= r_nf + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_scan && !stall) begin
            r_out <= scan_res;
        end else if (fin_go) begin
            r_out <= fin_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rdata <= r_mem[r_rd_idx[IdxW-1:0]];
        end
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
    end

    assign o_out.valid        = r_out_vld;
    assign o_out.kind         = r_out.kind;
    assign o_out.slot         = r_out.slot;
    assign o_out.found        = r_out.found;
    assign o_out.out_id       = r_out.out_id;
    assign o_out.retry_count  = r_out.retry_count;
    assign o_out.failed_count = r_out.failed_count;
    assign o_out.final_res    = r_out.final_res;

endmodule

`default_nettype wire
